>>> rtl/hashed_timing_wheel_assert.svh
// Assertion macros for the timing wheel.
`ifndef HASHED_TIMING_WHEEL_ASSERT_SVH
`define HASHED_TIMING_WHEEL_ASSERT_SVH
// Same-cycle implication, disabled in reset.
`define HTW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled in reset.
`define HTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/htw_pkg.sv
// Shared types and constants of the timing wheel.
package htw_pkg;
  localparam int MAX_SLOTS_DEF  = 256;
  localparam int NUM_TIMERS_DEF = 64;
  localparam int TICK_W = 16;
  localparam int SCNT_W = 9;
  localparam int ID_W   = 6;
  localparam int TIME_W = 32;
  localparam int DIV_W  = 32;

  localparam logic [TICK_W-1:0] TICK_RST = 16'd10;
  localparam logic [SCNT_W-1:0] SCNT_RST = 9'd256;

  localparam logic CFG_TICK  = 1'b0;
  localparam logic CFG_SLOTS = 1'b1;

  typedef enum logic [1:0] {
    MODE_REG   = 2'd0,
    MODE_UNREG = 2'd1,
    MODE_UPD   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_PENDING = 3'd2,
    ST_IDLE    = 3'd3,
    ST_EARLY   = 3'd4,
    ST_FIRED   = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_CHECK, S_CSMOD, S_CSWAIT, S_OPDIV,
    S_RGDIV, S_RGSLOT, S_RGLNK, S_RGPRV,
    S_URRD, S_URFIX, S_URCLR,
    S_UPDIV, S_UPSLOT, S_UPHEAD, S_UPNODE, S_UPFIRE, S_UPEND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;
endpackage

>>> rtl/hashed_timing_wheel.sv
// Top level of the single-level hashed timing wheel.
// Usage:
//  - Input channel (in_valid/in_ready) carries mode, timer_id, now_ms and
//    timeout_ms. Mode register links a timer into a slot, unregister unlinks
//    it, update fires every slot passed since the last update.
//  - Output channel (out_valid/out_ready) returns status, fired_id,
//    fire_time and last; last marks the final result of one input.
//  - Config channel (cfg_valid/cfg_ready) writes tick_ms (index 0) and
//    slot_count (index 1); always ready, write only while idle.
//  - One item at a time: in_ready is high only while the sequencer is idle.
//    Register and update wait on the shared divider, and divide once more
//    when the current slot lies beyond a shrunk slot count. Update walks
//    every slot passed and emits one result per fired timer, or a single
//    one when none fires.
//  - Reset clears config to tick 10 / 256 slots and then runs a clearing
//    pass over max(MAX_SLOTS, NUM_TIMERS) entries of the list memories with
//    in_ready low.
//  - Results sit in an output register; when the receiver stalls, the walk
//    holds until the pending transfer is taken.
module hashed_timing_wheel #(
  parameter int MAX_SLOTS  = htw_pkg::MAX_SLOTS_DEF,
  parameter int NUM_TIMERS = htw_pkg::NUM_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [5:0]  timer_id,
  input  logic [31:0] now_ms,
  input  logic [31:0] timeout_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [5:0]  fired_id,
  output logic [31:0] fire_time,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  `include "hashed_timing_wheel_assert.svh"

  localparam int SW    = $clog2(MAX_SLOTS);     // slot index
  localparam int EW    = SW + 1;                // slot count / idle mark
  localparam int EW1   = EW + 1;                // wrap sums
  localparam int IW    = $clog2(NUM_TIMERS);    // timer index
  localparam int LW    = IW + 1;                // link with null
  localparam int CLR_N = (MAX_SLOTS > NUM_TIMERS) ? MAX_SLOTS : NUM_TIMERS;
  localparam int CW    = $clog2(CLR_N);

  localparam logic [LW-1:0] NIL       = LW'(NUM_TIMERS);
  localparam logic [EW-1:0] IDLE_SLOT = EW'(MAX_SLOTS);

  htw_pkg::state_t state, state_next;

  // configuration
  logic [htw_pkg::TICK_W-1:0] tick_cfg;
  logic [htw_pkg::SCNT_W-1:0] scnt_cfg;
  logic [htw_pkg::TICK_W-1:0] tick_eff;
  logic [EW-1:0]              slots_eff;

  // wheel state
  logic [SW-1:0] cur_slot;
  logic [31:0]   last_upd;

  // latched item and working registers
  htw_pkg::mode_t   r_mode;
  logic [IW-1:0]    r_id;
  logic             r_id_bad;
  logic [31:0]      r_now;
  logic [31:0]      base;      // now - last update
  logic [31:0]      tmo_x;     // max(timeout - tick, 0)
  logic [SW-1:0]    cs_mod;
  logic [SW-1:0]    n_reg;
  logic [SW-1:0]    tgt;
  logic [EW-1:0]    ts_val;
  logic [LW-1:0]    hd;
  logic [EW-1:0]    steps;
  logic [EW-1:0]    step_i;
  logic [SW-1:0]    walk_s;
  logic [LW-1:0]    cur;
  logic [IW-1:0]    pend_id;
  logic             have_pend;
  htw_pkg::status_t res_status;
  logic [CW-1:0]    clr_cnt;

  // memories
  logic          sh_we, nx_we, pv_we, ts_we;
  logic [SW-1:0] sh_waddr, sh_raddr;
  logic [IW-1:0] nx_waddr, nx_raddr, pv_waddr, pv_raddr, ts_waddr, ts_raddr;
  logic [LW-1:0] sh_wdata, sh_rdata, nx_wdata, nx_rdata, pv_wdata, pv_rdata;
  logic [EW-1:0] ts_wdata, ts_rdata;

  htw_pkg::div_req_t div_req;
  htw_pkg::div_rsp_t div_rsp;

  // result emission
  logic             out_free;
  logic             em;
  htw_pkg::status_t em_status;
  logic [IW-1:0]    em_id;
  logic [31:0]      em_time;
  logic             em_last;

  // derived values
  logic [EW-1:0]  tgt_sum, tgt_c, walk_inc;
  logic [EW1-1:0] fin_sum, fin_c;

  htw_ram #(.DEPTH(MAX_SLOTS), .WIDTH(LW)) u_head (
    .clk(clk), .we(sh_we), .waddr(sh_waddr), .wdata(sh_wdata),
    .raddr(sh_raddr), .rdata(sh_rdata)
  );
  htw_ram #(.DEPTH(NUM_TIMERS), .WIDTH(LW)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );
  htw_ram #(.DEPTH(NUM_TIMERS), .WIDTH(LW)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(pv_raddr), .rdata(pv_rdata)
  );
  htw_ram #(.DEPTH(NUM_TIMERS), .WIDTH(EW)) u_tslot (
    .clk(clk), .we(ts_we), .waddr(ts_waddr), .wdata(ts_wdata),
    .raddr(ts_raddr), .rdata(ts_rdata)
  );

  htw_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // zero tick acts as one; slot count clamps to [1, MAX_SLOTS]
  assign tick_eff = (tick_cfg == '0) ? htw_pkg::TICK_W'(1) : tick_cfg;
  always_comb begin
    if (scnt_cfg == '0) begin
      slots_eff = EW'(1);
    end else if (32'(scnt_cfg) > 32'(MAX_SLOTS)) begin
      slots_eff = EW'(MAX_SLOTS);
    end else begin
      slots_eff = EW'(scnt_cfg);
    end
  end

  // slot for a register: (cs_mod + n) mod slots, both operands below slots
  assign tgt_sum  = EW'(cs_mod) + EW'(n_reg);
  assign tgt_c    = (tgt_sum >= slots_eff) ? tgt_sum - slots_eff : tgt_sum;
  assign walk_inc = EW'(walk_s) + EW'(1);
  assign fin_sum  = EW1'(cs_mod) + EW1'(steps);
  assign fin_c    = (fin_sum >= EW1'(slots_eff)) ? fin_sum - EW1'(slots_eff) : fin_sum;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == htw_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htw_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state, memory controls, divider requests, emission
  always_comb begin
    state_next = state;
    sh_we = 1'b0; sh_waddr = '0; sh_wdata = NIL; sh_raddr = '0;
    nx_we = 1'b0; nx_waddr = '0; nx_wdata = NIL; nx_raddr = '0;
    pv_we = 1'b0; pv_waddr = '0; pv_wdata = NIL; pv_raddr = '0;
    ts_we = 1'b0; ts_waddr = '0; ts_wdata = IDLE_SLOT; ts_raddr = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    em        = 1'b0;
    em_status = htw_pkg::ST_OK;
    em_id     = '0;
    em_time   = '0;
    em_last   = 1'b1;
    case (state)
      htw_pkg::S_CLEAR: begin
        sh_we    = (32'(clr_cnt) < 32'(MAX_SLOTS));
        sh_waddr = clr_cnt[SW-1:0];
        nx_we    = (32'(clr_cnt) < 32'(NUM_TIMERS));
        nx_waddr = clr_cnt[IW-1:0];
        pv_we    = nx_we;
        pv_waddr = clr_cnt[IW-1:0];
        ts_we    = nx_we;
        ts_waddr = clr_cnt[IW-1:0];
        if (clr_cnt == CW'(CLR_N - 1)) begin
          state_next = htw_pkg::S_IDLE;
        end
      end
      htw_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = htw_pkg::S_LOOKUP;
        end
      end
      htw_pkg::S_LOOKUP: begin
        ts_raddr = r_id;
        case (r_mode)
          htw_pkg::MODE_REG, htw_pkg::MODE_UNREG: begin
            state_next = r_id_bad ? htw_pkg::S_DONE : htw_pkg::S_CHECK;
          end
          htw_pkg::MODE_UPD: begin
            state_next = (base < 32'(tick_eff)) ? htw_pkg::S_DONE : htw_pkg::S_CSMOD;
          end
          default: state_next = htw_pkg::S_DONE;
        endcase
      end
      htw_pkg::S_CHECK: begin
        if (r_mode == htw_pkg::MODE_REG) begin
          state_next = (ts_rdata != IDLE_SLOT) ? htw_pkg::S_DONE : htw_pkg::S_CSMOD;
        end else begin
          state_next = (ts_rdata >= IDLE_SLOT) ? htw_pkg::S_DONE : htw_pkg::S_URRD;
        end
      end
      htw_pkg::S_CSMOD: begin
        // current slot may lie beyond a shrunk slot count
        if (EW'(cur_slot) < slots_eff) begin
          state_next = htw_pkg::S_OPDIV;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = 32'(cur_slot);
          div_req.divisor  = 32'(slots_eff);
          state_next       = htw_pkg::S_CSWAIT;
        end
      end
      htw_pkg::S_CSWAIT: begin
        if (div_rsp.done) begin
          state_next = htw_pkg::S_OPDIV;
        end
      end
      htw_pkg::S_OPDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = (r_mode == htw_pkg::MODE_REG) ? base + tmo_x : base;
        div_req.divisor  = 32'(tick_eff);
        state_next = (r_mode == htw_pkg::MODE_REG) ? htw_pkg::S_RGDIV : htw_pkg::S_UPDIV;
      end
      htw_pkg::S_RGDIV: begin
        if (div_rsp.done) begin
          state_next = (div_rsp.quot >= 32'(slots_eff)) ? htw_pkg::S_DONE
                                                         : htw_pkg::S_RGSLOT;
        end
      end
      htw_pkg::S_RGSLOT: begin
        sh_raddr   = tgt_c[SW-1:0];
        state_next = htw_pkg::S_RGLNK;
      end
      htw_pkg::S_RGLNK: begin
        // new timer becomes the list head
        nx_we    = 1'b1; nx_waddr = r_id; nx_wdata = sh_rdata;
        pv_we    = 1'b1; pv_waddr = r_id; pv_wdata = NIL;
        sh_we    = 1'b1; sh_waddr = tgt;  sh_wdata = LW'(r_id);
        ts_we    = 1'b1; ts_waddr = r_id; ts_wdata = EW'(tgt);
        state_next = htw_pkg::S_RGPRV;
      end
      htw_pkg::S_RGPRV: begin
        pv_we      = (hd != NIL);
        pv_waddr   = hd[IW-1:0];
        pv_wdata   = LW'(r_id);
        state_next = htw_pkg::S_DONE;
      end
      htw_pkg::S_URRD: begin
        nx_raddr   = r_id;
        pv_raddr   = r_id;
        state_next = htw_pkg::S_URFIX;
      end
      htw_pkg::S_URFIX: begin
        if (pv_rdata != NIL) begin
          nx_we = 1'b1; nx_waddr = pv_rdata[IW-1:0]; nx_wdata = nx_rdata;
        end else begin
          sh_we = 1'b1; sh_waddr = ts_val[SW-1:0]; sh_wdata = nx_rdata;
        end
        pv_we      = (nx_rdata != NIL);
        pv_waddr   = nx_rdata[IW-1:0];
        pv_wdata   = pv_rdata;
        state_next = htw_pkg::S_URCLR;
      end
      htw_pkg::S_URCLR: begin
        nx_we = 1'b1; nx_waddr = r_id;
        pv_we = 1'b1; pv_waddr = r_id;
        ts_we = 1'b1; ts_waddr = r_id;
        state_next = htw_pkg::S_DONE;
      end
      htw_pkg::S_UPDIV: begin
        if (div_rsp.done) begin
          state_next = htw_pkg::S_UPSLOT;
        end
      end
      htw_pkg::S_UPSLOT: begin
        sh_raddr   = walk_s;
        state_next = (step_i == steps) ? htw_pkg::S_UPEND : htw_pkg::S_UPHEAD;
      end
      htw_pkg::S_UPHEAD: begin
        sh_we      = 1'b1;
        sh_waddr   = walk_s;
        state_next = htw_pkg::S_UPNODE;
      end
      htw_pkg::S_UPNODE: begin
        nx_raddr   = cur[IW-1:0];
        state_next = (cur == NIL) ? htw_pkg::S_UPSLOT : htw_pkg::S_UPFIRE;
      end
      htw_pkg::S_UPFIRE: begin
        // one result is held back so that the final one can carry last
        nx_raddr = cur[IW-1:0];
        if (!have_pend || out_free) begin
          nx_we = 1'b1; nx_waddr = cur[IW-1:0];
          pv_we = 1'b1; pv_waddr = cur[IW-1:0];
          ts_we = 1'b1; ts_waddr = cur[IW-1:0];
          em        = have_pend;
          em_status = htw_pkg::ST_FIRED;
          em_id     = pend_id;
          em_time   = r_now;
          em_last   = 1'b0;
          state_next = htw_pkg::S_UPNODE;
        end
      end
      htw_pkg::S_UPEND: begin
        if (out_free) begin
          em = 1'b1;
          if (have_pend) begin
            em_status = htw_pkg::ST_FIRED;
            em_id     = pend_id;
            em_time   = r_now;
          end
          state_next = htw_pkg::S_IDLE;
        end
      end
      htw_pkg::S_DONE: begin
        if (out_free) begin
          em         = 1'b1;
          em_status  = res_status;
          state_next = htw_pkg::S_IDLE;
        end
      end
      default: state_next = htw_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_cfg  <= htw_pkg::TICK_RST;
      scnt_cfg  <= htw_pkg::SCNT_RST;
      cur_slot  <= '0;
      last_upd  <= '0;
      have_pend <= 1'b0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == htw_pkg::CFG_TICK) begin
          tick_cfg <= cfg_data;
        end else begin
          scnt_cfg <= cfg_data[htw_pkg::SCNT_W-1:0];
        end
      end
      if (state == htw_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == htw_pkg::S_UPFIRE && (!have_pend || out_free)) begin
        have_pend <= 1'b1;
      end
      if (state == htw_pkg::S_UPEND && out_free) begin
        have_pend <= 1'b0;
        cur_slot  <= fin_c[SW-1:0];
        last_upd  <= r_now;
      end
      if (em) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (em) begin
      status    <= em_status;
      fired_id  <= htw_pkg::ID_W'(em_id);
      fire_time <= em_time;
      last      <= em_last;
    end
    case (state)
      htw_pkg::S_IDLE: begin
        r_mode   <= htw_pkg::mode_t'(mode);
        r_id     <= timer_id[IW-1:0];
        r_id_bad <= (32'(timer_id) >= 32'(NUM_TIMERS));
        r_now    <= now_ms;
        base     <= now_ms - last_upd;
        tmo_x    <= (timeout_ms < 32'(tick_eff)) ? 32'd0 : timeout_ms - 32'(tick_eff);
      end
      htw_pkg::S_LOOKUP: begin
        if (r_mode == htw_pkg::MODE_UPD) begin
          res_status <= htw_pkg::ST_EARLY;
        end else begin
          res_status <= htw_pkg::ST_RANGE;
        end
      end
      htw_pkg::S_CHECK: begin
        ts_val <= ts_rdata;
        res_status <= (r_mode == htw_pkg::MODE_REG) ? htw_pkg::ST_PENDING
                                                    : htw_pkg::ST_IDLE;
      end
      htw_pkg::S_CSMOD: begin
        cs_mod <= cur_slot;
      end
      htw_pkg::S_CSWAIT: begin
        if (div_rsp.done) begin
          cs_mod <= div_rsp.rem[SW-1:0];
        end
      end
      htw_pkg::S_RGDIV: begin
        res_status <= htw_pkg::ST_RANGE;
        n_reg      <= div_rsp.quot[SW-1:0];
      end
      htw_pkg::S_RGSLOT: begin
        tgt <= tgt_c[SW-1:0];
      end
      htw_pkg::S_RGLNK: begin
        hd         <= sh_rdata;
        res_status <= htw_pkg::ST_OK;
      end
      htw_pkg::S_URFIX: begin
        res_status <= htw_pkg::ST_OK;
      end
      htw_pkg::S_UPDIV: begin
        steps  <= (div_rsp.quot > 32'(slots_eff)) ? slots_eff : EW'(div_rsp.quot);
        step_i <= '0;
        walk_s <= cs_mod;
      end
      htw_pkg::S_UPHEAD: begin
        cur    <= sh_rdata;
        step_i <= step_i + 1'b1;
        walk_s <= (walk_inc == slots_eff) ? '0 : walk_inc[SW-1:0];
      end
      htw_pkg::S_UPFIRE: begin
        if (!have_pend || out_free) begin
          pend_id <= cur[IW-1:0];
          cur     <= nx_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  // one item in flight: the sequencer leaves idle on every transfer
  `HTW_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready,
    "input taken while an item is in flight")
  // divider results only arrive while the sequencer waits for them
  `HTW_ASSERT_SAME(a_div_owner, div_rsp.done,
    state == htw_pkg::S_CSWAIT || state == htw_pkg::S_RGDIV || state == htw_pkg::S_UPDIV,
    "divider done outside a wait state")
  // walk pointer stays inside the active slots
  `HTW_ASSERT_SAME(a_walk_range, state == htw_pkg::S_UPHEAD, EW'(walk_s) < slots_eff,
    "walk slot beyond slot count")
  // fired results name a real timer
  `HTW_ASSERT_SAME(a_fired_id, out_valid && status == htw_pkg::ST_FIRED,
    32'(fired_id) < 32'(NUM_TIMERS), "fired id beyond timer table")
endmodule

>>> rtl/htw_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
module htw_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 7
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/htw_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module htw_div (
  input  logic              clk,
  input  logic              rst,
  input  htw_pkg::div_req_t req,
  output htw_pkg::div_rsp_t rsp
);
  localparam int CNT_W = $clog2(htw_pkg::DIV_W);

  logic                      busy;
  logic                      done;
  logic [CNT_W-1:0]          cnt;
  logic [htw_pkg::DIV_W-1:0] quot;
  logic [htw_pkg::DIV_W-1:0] rem;
  logic [htw_pkg::DIV_W-1:0] dvs;
  logic [htw_pkg::DIV_W:0]   sh;
  logic [htw_pkg::DIV_W:0]   diff;
  logic                      ge;

  always_comb begin
    sh   = {rem, quot[htw_pkg::DIV_W-1]};
    diff = sh - {1'b0, dvs};
    ge   = (sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(htw_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      rem  <= ge ? diff[htw_pkg::DIV_W-1:0] : sh[htw_pkg::DIV_W-1:0];
      quot <= {quot[htw_pkg::DIV_W-2:0], ge};
    end else if (req.start) begin
      rem  <= '0;
      quot <= req.dividend;
      dvs  <= req.divisor;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;
endmodule

>>> dv/htw_checker.sv
// Transfer monitor, wheel predictor and result comparison for the timing wheel.
module htw_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [5:0]  timer_id,
  input  logic [31:0] now_ms,
  input  logic [31:0] timeout_ms,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [5:0]  fired_id,
  input  logic [31:0] fire_time,
  input  logic        last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = htw_pkg::MAX_SLOTS_DEF;
  localparam int NTMR  = htw_pkg::NUM_TIMERS_DEF;
  localparam logic [6:0] NIL  = 7'(NTMR);
  localparam logic [8:0] NOSL = 9'(NSLOT);

  typedef struct {
    logic [2:0]  st;
    logic [5:0]  id;
    logic [31:0] t;
    logic        lst;
  } wheel_result_t;

  wheel_result_t fire_q[$];

  logic [15:0] tick;
  logic [8:0]  slots;
  logic [6:0]  slot_head [NSLOT];
  logic [6:0]  nxt [NTMR];
  logic [6:0]  prv [NTMR];
  logic [8:0]  tslot [NTMR];
  logic [31:0] cur_slot;
  logic [31:0] last_upd;

  task automatic add_result(input logic [2:0] st, input logic [5:0] id,
                            input logic [31:0] t, input logic lst);
    wheel_result_t r;
    r.st = st; r.id = id; r.t = t; r.lst = lst;
    fire_q.push_back(r);
  endtask

  task automatic wheel_step(input logic [1:0] m, input logic [5:0] id,
                            input logic [31:0] now, input logic [31:0] tmo_in);
    logic [31:0] tk, ns, n, iv, steps, s, tmo;
    logic [6:0] cur, nx, pv;
    int k;
    wheel_result_t r;
    tk = (tick == 0) ? 32'd1 : 32'(tick);
    ns = (slots == 0) ? 32'd1 : (slots > 9'(NSLOT) ? 32'(NSLOT) : 32'(slots));
    tmo = tmo_in;
    k = 0;
    case (m)
      htw_pkg::MODE_REG: begin
        if (tslot[id] != NOSL) begin
          add_result(htw_pkg::ST_PENDING, 0, 0, 1);
        end else begin
          if (tmo < tk) tmo = tk;
          n = (now + tmo - last_upd - tk) / tk;
          if (n >= ns) begin
            add_result(htw_pkg::ST_RANGE, 0, 0, 1);
          end else begin
            s = (cur_slot + n) % ns;
            nxt[id] = slot_head[s];
            prv[id] = NIL;
            if (slot_head[s] != NIL) prv[slot_head[s][5:0]] = {1'b0, id};
            slot_head[s] = {1'b0, id};
            tslot[id] = s[8:0];
            add_result(htw_pkg::ST_OK, 0, 0, 1);
          end
        end
      end
      htw_pkg::MODE_UNREG: begin
        if (tslot[id] == NOSL) begin
          add_result(htw_pkg::ST_IDLE, 0, 0, 1);
        end else begin
          nx = nxt[id];
          pv = prv[id];
          if (pv != NIL) nxt[pv[5:0]] = nx;
          else slot_head[tslot[id]] = nx;
          if (nx != NIL) prv[nx[5:0]] = pv;
          nxt[id] = NIL;
          prv[id] = NIL;
          tslot[id] = NOSL;
          add_result(htw_pkg::ST_OK, 0, 0, 1);
        end
      end
      htw_pkg::MODE_UPD: begin
        iv = now - last_upd;
        if (iv < tk) begin
          add_result(htw_pkg::ST_EARLY, 0, 0, 1);
        end else begin
          steps = iv / tk;
          if (steps > ns) steps = ns;
          for (int i = 0; i < int'(steps); i++) begin
            s = (cur_slot + 32'(i)) % ns;
            cur = slot_head[s];
            slot_head[s] = NIL;
            while (cur != NIL) begin
              nx = nxt[cur[5:0]];
              nxt[cur[5:0]] = NIL;
              prv[cur[5:0]] = NIL;
              tslot[cur[5:0]] = NOSL;
              add_result(htw_pkg::ST_FIRED, cur[5:0], now, 0);
              k++;
              cur = nx;
            end
          end
          cur_slot = (cur_slot + steps) % ns;
          last_upd = now;
          if (k == 0) begin
            add_result(htw_pkg::ST_OK, 0, 0, 1);
          end else begin
            r = fire_q.pop_back();
            r.lst = 1;
            fire_q.push_back(r);
          end
        end
      end
      default: add_result(htw_pkg::ST_RANGE, 0, 0, 1);
    endcase
  endtask

  task automatic compare_result();
    wheel_result_t e;
    if (fire_q.size() == 0) begin
      $display("%0t: unexpected result status=%0d id=%0d time=%0h last=%0b",
               $realtime, status, fired_id, fire_time, last);
      fails++;
    end else begin
      e = fire_q.pop_front();
      if (status !== e.st) begin
        $display("%0t: status expected %0d actual %0d", $realtime, e.st, status);
        fails++;
      end
      if (fired_id !== e.id) begin
        $display("%0t: fired_id expected %0d actual %0d", $realtime, e.id, fired_id);
        fails++;
      end
      if (fire_time !== e.t) begin
        $display("%0t: fire_time expected %0h actual %0h", $realtime, e.t, fire_time);
        fails++;
      end
      if (last !== e.lst) begin
        $display("%0t: last expected %0b actual %0b", $realtime, e.lst, last);
        fails++;
      end
    end
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      tick = htw_pkg::TICK_RST;
      slots = htw_pkg::SCNT_RST;
      for (int i = 0; i < NSLOT; i++) slot_head[i] = NIL;
      for (int i = 0; i < NTMR; i++) begin
        nxt[i] = NIL;
        prv[i] = NIL;
        tslot[i] = NOSL;
      end
      cur_slot = 0;
      last_upd = 0;
      fire_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == htw_pkg::CFG_TICK) tick = cfg_data;
        else slots = cfg_data[8:0];
      end
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready) wheel_step(mode, timer_id, now_ms, timeout_ms);
    end
    pending = fire_q.size();
  end
endmodule

>>> dv/tb_hashed_timing_wheel.sv
// Stimulus, flow control and verdict for the timing wheel testbench.
module tb_hashed_timing_wheel;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        in_valid, in_ready;
  logic [1:0]  mode;
  logic [5:0]  timer_id;
  logic [31:0] now_ms, timeout_ms;
  logic        out_valid, out_ready;
  logic [2:0]  status;
  logic [5:0]  fired_id;
  logic [31:0] fire_time;
  logic        last;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [15:0] cfg_data;
  int          fails, pending;

  // Flow-control knobs shared between the sender and the receiver process.
  bit          quiet;      // no idling at all near the end
  int          hold_req;   // bumped by the sender to ask for one long stall
  int          hold_seen;
  int          long_hold;
  int          stall;
  int          idle_cycles;

  // Model of the current settings, used only to shape well-formed items.
  logic [31:0] wall;       // running wheel time
  int unsigned tk_eff, ns_eff;

  hashed_timing_wheel DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .timer_id(timer_id), .now_ms(now_ms), .timeout_ms(timeout_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .fired_id(fired_id), .fire_time(fire_time), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  htw_checker u_checker (.*);

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // output register backs up and in_ready stays low while items are offered.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      long_hold <= 0;
      stall <= 0;
      hold_seen <= 0;
    end else if (long_hold > 0) begin
      out_ready <= 1'b0;
      long_hold <= long_hold - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      long_hold <= 400;
      out_ready <= 1'b0;
    end else if (stall > 0) begin
      out_ready <= 1'b0;
      stall <= stall - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      stall <= $urandom_range(1, 19) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: any cycle without a transfer on some channel counts toward the limit.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // One input transfer, sometimes after a random idle gap; with quiet set, valid stays high between back-to-back items.
  task automatic send(input logic [1:0] m, input logic [5:0] id,
                      input logic [31:0] now, input logic [31:0] tmo);
    bit got;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    timer_id <= id;
    now_ms <= now;
    timeout_ms <= tmo;
    do begin
      @(negedge clk);
      got = in_ready;
      @(posedge clk);
    end while (!got);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    bit got;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      got = cfg_ready;
      @(posedge clk);
    end while (!got);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] t, input logic [15:0] sc);
    drain();
    write_reg(htw_pkg::CFG_TICK, t);
    write_reg(htw_pkg::CFG_SLOTS, sc);
    cfg_valid <= 1'b0;
    @(posedge clk);
    tk_eff = (t == 0) ? 1 : t;
    ns_eff = (sc[8:0] == 0) ? 1 : ((sc[8:0] > 9'd256) ? 256 : sc[8:0]);
  endtask

  // Mostly coherent register/unregister/update traffic around the wheel
  // time, with a share of arbitrary noise items.
  task automatic random_items(input int count);
    logic [63:0] tmo;
    int unsigned adv;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 4))
          0, 1: begin
            tmo = 64'(tk_eff) * $urandom_range(0, ns_eff + 1) +
                  $urandom_range(0, tk_eff - 1);
            send(htw_pkg::MODE_REG, 6'($urandom_range(0, 63)),
                 wall + $urandom_range(0, tk_eff - 1), tmo[31:0]);
          end
          2: send(htw_pkg::MODE_UNREG, 6'($urandom_range(0, 63)), $urandom, $urandom);
          default: begin
            if ($urandom_range(0, 4) != 0) adv = $urandom_range(0, 4);
            else adv = $urandom_range(0, ns_eff + 2);
            wall = wall + 32'(adv * tk_eff) + $urandom_range(0, tk_eff - 1);
            send(htw_pkg::MODE_UPD, 6'($urandom), wall, $urandom);
          end
        endcase
      end else begin
        send(2'($urandom_range(0, 3)), 6'($urandom), $urandom, $urandom);
      end
    end
  endtask

  logic [15:0] tick_set [7] = '{16'd1, 16'd65535, 16'd0, 16'd3, 16'd7, 16'd10, 16'd1};
  logic [15:0] slot_set [7] = '{16'd1, 16'd256, 16'd0, 16'd300, 16'd16, 16'd8, 16'd64};

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    mode <= htw_pkg::MODE_REG;
    timer_id <= '0;
    now_ms <= '0;
    timeout_ms <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= htw_pkg::CFG_TICK;
    cfg_data <= '0;
    quiet = 0;
    hold_req = 0;
    tk_eff = 10;
    ns_eff = 256;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings (tick 10, 256 slots).
    send(htw_pkg::MODE_REG, 6'd0, 32'd0, 32'd0);              // timeout raised to a tick
    send(htw_pkg::MODE_REG, 6'd0, 32'd0, 32'd50);             // already pending
    send(htw_pkg::MODE_UNREG, 6'd5, 32'd0, 32'd0);            // idle timer
    send(htw_pkg::MODE_UNREG, 6'd0, 32'd0, 32'd0);
    send(htw_pkg::MODE_REG, 6'd63, 32'd0, 32'd2560);          // last usable slot
    send(htw_pkg::MODE_REG, 6'd1, 32'd0, 32'd2570);           // one slot too far
    send(htw_pkg::MODE_REG, 6'd1, 32'd0, 32'hFFFF_FFFF);      // far beyond the last slot
    send(2'd3, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);          // unused mode
    send(htw_pkg::MODE_UPD, 6'd0, 32'd5, 32'd0);              // too early
    send(htw_pkg::MODE_REG, 6'd2, 32'd0, 32'd10);
    send(htw_pkg::MODE_REG, 6'd3, 32'd0, 32'd10);
    send(htw_pkg::MODE_REG, 6'd4, 32'd0, 32'd10);
    send(htw_pkg::MODE_UPD, 6'd0, 32'd10, 32'd0);             // fires 4, 3, 2 head first
    send(htw_pkg::MODE_REG, 6'd5, 32'd10, 32'd30);
    send(htw_pkg::MODE_REG, 6'd6, 32'd10, 32'd30);
    send(htw_pkg::MODE_REG, 6'd7, 32'd10, 32'd30);
    send(htw_pkg::MODE_UNREG, 6'd6, 32'd0, 32'd0);            // unlink from mid list
    send(htw_pkg::MODE_UNREG, 6'd7, 32'd0, 32'd0);            // unlink the head
    send(htw_pkg::MODE_UPD, 6'd0, 32'hFFFF_FFFF, 32'd0);      // full turn fires all
    send(htw_pkg::MODE_UPD, 6'd0, 32'd0, 32'd0);              // wrapped, too early
    wall = 32'hFFFF_FFFF;

    // Sender pauses until every expected result is back, then the settings
    // sweep runs. Each phase leaves timers pending for the next one, which
    // covers slots beyond a shrunk slot count.
    for (int p = 0; p < 7; p++) begin
      apply_setting(tick_set[p], slot_set[p]);
      if (p == 1) begin
        random_items(30);
        hold_req = hold_req + 1;   // long receiver stall while items keep coming
        random_items(34);
      end else if (p == 6) begin
        random_items(34);
        quiet = 1;
        random_items(30);
      end else begin
        random_items(64);
      end
    end

    drain();
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
